@@ hdl/mhpq_pkg.sv @@
package mhpq_pkg;

  localparam int DEPTH         = 64;
  localparam int KEY_WIDTH     = 32;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int FILL_W        = $clog2(DEPTH + 1);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [KEY_WIDTH-1:0]     key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic [KEY_WIDTH-1:0]     out_key;
    logic [PAYLOAD_WIDTH-1:0] out_payload;
    logic [FILL_W-1:0]        fill;
  } out_word_t;

endpackage

@@ hdl/min_heap_priority_queue.sv @@
// channel  dir  handshake          word
// req      in   req_valid/stall    cmd, key, payload
// rsp      out  rsp_valid/stall    status, out_key, out_payload, fill
//
// one word at a time; the entries sit in a single ram with one write and one
// registered read port, so each step of the sift costs ram accesses
// push: climbs L levels, up to log2(DEPTH); a full or an empty heap needs no climb
// pop: reads up to two children per level compared, with one more write when the
// entry lands on a leaf; an empty heap needs no sift
// synchronous reset clears the fill count, the fsm and rsp_valid; ram contents are left
// a stalled rsp word holds; the next req word is taken while it waits
module min_heap_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mhpq_pkg::in_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mhpq_pkg::out_word_t rsp
);

  localparam int IW = mhpq_pkg::IDX_W;
  localparam int CW = mhpq_pkg::IDX_W + 2;

  typedef struct packed {
    logic [mhpq_pkg::KEY_WIDTH-1:0]     key;
    logic [mhpq_pkg::PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_L,
    S_DN_R,
    S_PLACE,
    S_EMIT
  } state_t;

  // entry ram
  entry_t          mem [mhpq_pkg::DEPTH];
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  entry_t          rd_data;

  state_t                      state, state_next;
  logic [mhpq_pkg::FILL_W-1:0] count, count_next;
  logic [IW-1:0]               pos, pos_next;
  entry_t                      cur, cur_next;
  entry_t                      child, child_next;
  mhpq_pkg::status_t           res_status, res_status_next;
  entry_t                      res, res_next;
  logic                        rsp_valid_next;
  mhpq_pkg::out_word_t         rsp_next;

  logic [CW-1:0] n_ext;
  logic [CW-1:0] left_w;
  logic [CW-1:0] right_w;
  logic [IW-1:0] par;
  logic [IW-1:0] gpar;
  entry_t        sel;
  logic [CW-1:0] sel_idx;
  logic [CW-1:0] sel_left;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign req_stall = (state != S_IDLE);

  assign n_ext   = CW'(count);
  assign left_w  = CW'({pos, 1'b1});
  assign right_w = left_w + CW'(1);
  assign par     = IW'((pos - IW'(1)) >> 1);
  assign gpar    = IW'((par - IW'(1)) >> 1);

  // smaller child, left wins on equal keys
  always_comb begin
    sel     = rd_data;
    sel_idx = left_w;
    if (state == S_DN_R) begin
      if (rd_data.key < child.key) begin
        sel     = rd_data;
        sel_idx = right_w;
      end else begin
        sel     = child;
        sel_idx = left_w;
      end
    end
  end

  assign sel_left = CW'({sel_idx[IW-1:0], 1'b1});

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    cur_next        = cur;
    child_next      = child;
    res_status_next = res_status;
    res_next        = res;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = cur;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          res_status_next = mhpq_pkg::ST_OK;
          res_next        = '0;
          cur_next        = '{key: req.key, payload: req.payload};
          unique case (req.cmd)
            mhpq_pkg::CMD_PUSH: begin
              if (count == mhpq_pkg::FILL_W'(mhpq_pkg::DEPTH)) begin
                res_status_next = mhpq_pkg::ST_FULL;
                state_next      = S_EMIT;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{key: req.key, payload: req.payload};
                count_next = count + mhpq_pkg::FILL_W'(1);
                state_next = S_EMIT;
              end else begin
                pos_next   = count[IW-1:0];
                rd_en      = 1'b1;
                rd_addr    = IW'((count[IW-1:0] - IW'(1)) >> 1);
                count_next = count + mhpq_pkg::FILL_W'(1);
                state_next = S_UP_CMP;
              end
            end
            mhpq_pkg::CMD_POP: begin
              if (count == '0) begin
                res_status_next = mhpq_pkg::ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                count_next = count - mhpq_pkg::FILL_W'(1);
                state_next = S_POP_ROOT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // rd_data holds the parent of the hole at pos
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_data.key <= cur.key) begin
          wr_data    = cur;
          state_next = S_EMIT;
        end else begin
          wr_data  = rd_data;
          pos_next = par;
          if (par == '0) begin
            state_next = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = gpar;
          end
        end
      end

      S_POP_ROOT: begin
        res_next = rd_data;
        if (count == '0) begin
          state_next = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = count[IW-1:0];
          state_next = S_POP_LAST;
        end
      end

      // last entry becomes the moving element, hole at the root
      S_POP_LAST: begin
        cur_next = rd_data;
        pos_next = '0;
        if (CW'(1) < n_ext) begin
          rd_en      = 1'b1;
          rd_addr    = IW'(1);
          state_next = S_DN_L;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = rd_data;
          state_next = S_EMIT;
        end
      end

      S_DN_L, S_DN_R: begin
        if (state == S_DN_L && right_w < n_ext) begin
          child_next = rd_data;
          rd_en      = 1'b1;
          rd_addr    = right_w[IW-1:0];
          state_next = S_DN_R;
        end else begin
          wr_en = 1'b1;
          if (sel.key < cur.key) begin
            wr_data  = sel;
            pos_next = sel_idx[IW-1:0];
            if (sel_left < n_ext) begin
              rd_en      = 1'b1;
              rd_addr    = sel_left[IW-1:0];
              state_next = S_DN_L;
            end else begin
              state_next = S_PLACE;
            end
          end else begin
            wr_data    = cur;
            state_next = S_EMIT;
          end
        end
      end

      S_PLACE: begin
        wr_en      = 1'b1;
        wr_data    = cur;
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.status      = res_status;
          rsp_next.out_key     = res.key;
          rsp_next.out_payload = res.payload;
          rsp_next.fill        = count;
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    pos        <= pos_next;
    cur        <= cur_next;
    child      <= child_next;
    res_status <= res_status_next;
    res        <= res_next;
    rsp        <= rsp_next;
  end

endmodule

@@ test/mhpq_checker.sv @@
module mhpq_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_stall,
  input  mhpq_pkg::in_word_t  req,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  mhpq_pkg::out_word_t rsp,
  output int                  mismatches,
  output int                  pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [mhpq_pkg::KEY_WIDTH-1:0]     slot_key     [mhpq_pkg::DEPTH];
  logic [mhpq_pkg::PAYLOAD_WIDTH-1:0] slot_payload [mhpq_pkg::DEPTH];
  int unsigned                        held;
  mhpq_pkg::out_word_t                expected_rsp_q[$];

  // applies one req word to the shadow heap and returns the rsp word it yields
  function automatic mhpq_pkg::out_word_t heap_apply(mhpq_pkg::in_word_t w);
    mhpq_pkg::out_word_t                r;
    int unsigned                        pos;
    int unsigned                        up;
    int unsigned                        lc;
    int unsigned                        rc;
    int unsigned                        least;
    bit                                 settled;
    logic [mhpq_pkg::KEY_WIDTH-1:0]     tk;
    logic [mhpq_pkg::PAYLOAD_WIDTH-1:0] tp;
    r = '0;
    r.status = mhpq_pkg::ST_OK;
    if (w.cmd == mhpq_pkg::CMD_PUSH) begin
      if (held >= mhpq_pkg::DEPTH) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        pos = held;
        held++;
        settled = 1'b0;
        // parents with a strictly larger key move down
        while (pos > 0 && !settled) begin
          up = (pos - 1) / 2;
          if (slot_key[up] <= w.key) begin
            settled = 1'b1;
          end else begin
            slot_key[pos]     = slot_key[up];
            slot_payload[pos] = slot_payload[up];
            pos = up;
          end
        end
        slot_key[pos]     = w.key;
        slot_payload[pos] = w.payload;
      end
    end else if (held == 0) begin
      r.status = mhpq_pkg::ST_EMPTY;
    end else begin
      r.out_key     = slot_key[0];
      r.out_payload = slot_payload[0];
      held--;
      slot_key[0]     = slot_key[held];
      slot_payload[0] = slot_payload[held];
      pos = 0;
      settled = 1'b0;
      // left child wins a tie since the right one must be strictly smaller
      while (!settled) begin
        least = pos;
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc < held && slot_key[lc] < slot_key[least]) least = lc;
        if (rc < held && slot_key[rc] < slot_key[least]) least = rc;
        if (least == pos) begin
          settled = 1'b1;
        end else begin
          tk = slot_key[pos];
          tp = slot_payload[pos];
          slot_key[pos]       = slot_key[least];
          slot_payload[pos]   = slot_payload[least];
          slot_key[least]     = tk;
          slot_payload[least] = tp;
          pos = least;
        end
      end
    end
    r.fill = mhpq_pkg::FILL_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    mhpq_pkg::out_word_t want;
    int                  miss;
    miss = 0;
    if (rst) begin
      held = 0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("rsp word with none expected: status %0d, out_key %0h, fill %0d",
                 rsp.status, rsp.out_key, rsp.fill);
          miss++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            miss++;
          end
          if (rsp.out_key !== want.out_key) begin
            $error("out_key: expected %0h, got %0h", want.out_key, rsp.out_key);
            miss++;
          end
          if (rsp.out_payload !== want.out_payload) begin
            $error("out_payload: expected %0h, got %0h", want.out_payload,
                   rsp.out_payload);
            miss++;
          end
          if (rsp.fill !== want.fill) begin
            $error("fill: expected %0d, got %0d", want.fill, rsp.fill);
            miss++;
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp_q.push_back(heap_apply(req));
    end
    mismatches <= mismatches + miss;
    pending    <= expected_rsp_q.size();
  end

endmodule

@@ test/tb_min_heap_priority_queue.sv @@
module tb_min_heap_priority_queue;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1450;
  localparam int PHASE_LEN    = 120;
  localparam int CALM_TAIL    = 150;

  logic                clk;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  mhpq_pkg::in_word_t  req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  mhpq_pkg::out_word_t rsp;
  int                  mismatches;
  int                  pending;
  bit                  calm      = 1'b0;

  min_heap_priority_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  mhpq_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("min_heap_priority_queue: mismatch");
    $finish;
  end

  // rsp side backpressure in bursts, always followed by a free cycle
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk);
        @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // returns right after the rising edge that accepts the word
  task automatic send_word(mhpq_pkg::in_word_t w, int gap);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic push_word(logic [mhpq_pkg::KEY_WIDTH-1:0]     k,
                           logic [mhpq_pkg::PAYLOAD_WIDTH-1:0] p);
    mhpq_pkg::in_word_t w;
    w.cmd     = mhpq_pkg::CMD_PUSH;
    w.key     = k;
    w.payload = p;
    send_word(w, 0);
  endtask

  // key and payload of a pop are don't-care, so they carry noise
  task automatic pop_word();
    mhpq_pkg::in_word_t w;
    w.cmd     = mhpq_pkg::CMD_POP;
    w.key     = $urandom;
    w.payload = mhpq_pkg::PAYLOAD_WIDTH'($urandom_range(0, 16'hFFFF));
    send_word(w, 0);
  endtask

  function automatic logic [mhpq_pkg::KEY_WIDTH-1:0] draw_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 1;
          2: return '1;
          default: return {mhpq_pkg::KEY_WIDTH{1'b1}} - 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    mhpq_pkg::in_word_t w;
    int                 push_pct;
    int                 gap;
    int                 phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pop, key extremes, ties on push and on sift down
    pop_word();
    push_word('1, 16'hFFFF);
    push_word('0, 16'h0000);
    push_word(7, 16'h000A);
    push_word(7, 16'h000B);
    push_word(7, 16'h000C);
    push_word(7, 16'h000D);
    repeat (6) pop_word();
    pop_word();
    push_word(32'h8000_0000, 16'h8000);
    push_word(32'h7FFF_FFFF, 16'h7FFF);
    push_word(1, 16'h0001);
    push_word(1, 16'h0002);
    push_word(1, 16'h0003);
    repeat (6) pop_word();

    // random: phases of push-heavy, pop-heavy and balanced traffic
    push_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_LEN == 0) begin
        phase = n / PHASE_LEN;
        case (phase)
          0: push_pct = 97;  // fill up and overflow
          1: push_pct = 3;   // drain and underflow
          default: begin
            case ($urandom_range(0, 4))
              0: push_pct = 80;
              1: push_pct = 55;
              2: push_pct = 50;
              3: push_pct = 45;
              default: push_pct = 20;
            endcase
          end
        endcase
        calm = (phase % 3 == 2);
      end
      if (n >= RANDOM_WORDS - CALM_TAIL) calm = 1'b1;
      w.cmd     = ($urandom_range(0, 99) < push_pct) ? mhpq_pkg::CMD_PUSH
                                                     : mhpq_pkg::CMD_POP;
      w.key     = draw_key();
      w.payload = mhpq_pkg::PAYLOAD_WIDTH'($urandom_range(0, 16'hFFFF));
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      send_word(w, gap);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("min_heap_priority_queue: match");
    end else begin
      $display("min_heap_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
